### rtl/s20_pkg.sv
// ----------------------------------------------------------------------------
// s20_pkg
// shared types and constants for the salsa20 block core
// ----------------------------------------------------------------------------
package s20_pkg;

	localparam int NWORDS = 16;

	typedef logic [31:0] word_t;
	typedef logic [NWORDS-1:0][31:0] state_t;
	typedef logic [3:0] rounds_t;

	typedef logic [1:0] cfg_index_t;
	typedef logic [3:0] cfg_data_t;

	localparam cfg_index_t CFG_DOUBLE_ROUNDS = 2'd0;
	localparam cfg_index_t CFG_FEED_FORWARD  = 2'd1;

	localparam rounds_t RESET_DOUBLE_ROUNDS = 4'd4;
	localparam logic    RESET_FEED_FORWARD  = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic round;
		logic row;
		logic finish;
	} cmd_t;

endpackage

### rtl/s20_datapath.sv
// ----------------------------------------------------------------------------
// s20_datapath
// state and original-word registers, one column or row round per cycle,
// optional feed-forward add into the output register
// ----------------------------------------------------------------------------
module s20_datapath (
	input  logic          clk,
	input  s20_pkg::cmd_t cmd,
	input  logic          feed_forward,
	input  s20_pkg::state_t in_words,
	output s20_pkg::state_t out_words
);

	typedef logic [3:0][31:0] quad_t;

	s20_pkg::state_t state_q;
	s20_pkg::state_t orig_q;
	s20_pkg::state_t out_q;
	s20_pkg::state_t next_state;

	function automatic s20_pkg::word_t rotl(input s20_pkg::word_t v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// a, b, c, d in elements 0..3
	function automatic quad_t quarter(input quad_t x);
		s20_pkg::word_t a;
		s20_pkg::word_t b;
		s20_pkg::word_t c;
		s20_pkg::word_t d;
		quad_t r;
		a = x[0];
		b = x[1];
		c = x[2];
		d = x[3];
		b = b ^ rotl(a + d, 7);
		c = c ^ rotl(b + a, 9);
		d = d ^ rotl(c + b, 13);
		a = a ^ rotl(d + c, 18);
		r[0] = a;
		r[1] = b;
		r[2] = c;
		r[3] = d;
		return r;
	endfunction

	quad_t q0;
	quad_t q1;
	quad_t q2;
	quad_t q3;

	always_comb begin
		next_state = state_q;
		if (cmd.row) begin
			q0 = quarter({state_q[3],  state_q[2],  state_q[1],  state_q[0]});
			q1 = quarter({state_q[4],  state_q[7],  state_q[6],  state_q[5]});
			q2 = quarter({state_q[9],  state_q[8],  state_q[11], state_q[10]});
			q3 = quarter({state_q[14], state_q[13], state_q[12], state_q[15]});
			{next_state[3],  next_state[2],  next_state[1],  next_state[0]}  = q0;
			{next_state[4],  next_state[7],  next_state[6],  next_state[5]}  = q1;
			{next_state[9],  next_state[8],  next_state[11], next_state[10]} = q2;
			{next_state[14], next_state[13], next_state[12], next_state[15]} = q3;
		end else begin
			q0 = quarter({state_q[12], state_q[8],  state_q[4],  state_q[0]});
			q1 = quarter({state_q[1],  state_q[13], state_q[9],  state_q[5]});
			q2 = quarter({state_q[6],  state_q[2],  state_q[14], state_q[10]});
			q3 = quarter({state_q[11], state_q[7],  state_q[3],  state_q[15]});
			{next_state[12], next_state[8],  next_state[4],  next_state[0]}  = q0;
			{next_state[1],  next_state[13], next_state[9],  next_state[5]}  = q1;
			{next_state[6],  next_state[2],  next_state[14], next_state[10]} = q2;
			{next_state[11], next_state[7],  next_state[3],  next_state[15]} = q3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= in_words;
			orig_q  <= in_words;
		end else if (cmd.round) begin
			state_q <= next_state;
		end
		if (cmd.finish) begin
			for (int i = 0; i < s20_pkg::NWORDS; i++) begin
				out_q[i] <= state_q[i] + (feed_forward ? orig_q[i] : 32'd0);
			end
		end
	end

	assign out_words = out_q;

endmodule

### rtl/s20_ctrl.sv
// ----------------------------------------------------------------------------
// s20_ctrl
// sequencer: accepts a beat, steps the half-round count, hands the result
// to the output register and keeps its valid flag
// ----------------------------------------------------------------------------
module s20_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  s20_pkg::rounds_t double_rounds,
	output s20_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		IDLE,
		ROUND,
		FINISH
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic [4:0] last_cnt;
	logic       in_take;
	logic       out_free;

	assign last_cnt = {double_rounds, 1'b0} - 5'd1;
	assign in_take  = (state_q == IDLE) && in_valid;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd.load   = in_take;
		cmd.round  = (state_q == ROUND);
		cmd.row    = cnt_q[0];
		cmd.finish = (state_q == FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					cnt_q <= 5'd0;
					if (in_valid) begin
						state_q <= (double_rounds == 4'd0) ? FINISH : ROUND;
					end
				end
				ROUND: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == last_cnt) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;

endmodule

### rtl/salsa20_core.sv
// an accepted beat is loaded, stepped in ROUND if double rounds are nonzero, and written
// to the output register in FINISH, where out_valid is set; new beats wait until IDLE
// the round unit does one column or row round per cycle; FINISH adds the optional feed-forward
// arst_n clears the sequencer and the output valid flag
// reset setting: 4 double rounds, feed-forward on
// ----------------------------------------------------------------------------
// salsa20_core
// salsa20 block core with configurable double rounds and feed-forward
// ----------------------------------------------------------------------------
module salsa20_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  s20_pkg::cfg_index_t   cfg_index,
	input  s20_pkg::cfg_data_t    cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [63:0]           words_0_1,
	input  logic [63:0]           words_2_3,
	input  logic [63:0]           words_4_5,
	input  logic [63:0]           words_6_7,
	input  logic [63:0]           words_8_9,
	input  logic [63:0]           words_10_11,
	input  logic [63:0]           words_12_13,
	input  logic [63:0]           words_14_15,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           out_0_1,
	output logic [63:0]           out_2_3,
	output logic [63:0]           out_4_5,
	output logic [63:0]           out_6_7,
	output logic [63:0]           out_8_9,
	output logic [63:0]           out_10_11,
	output logic [63:0]           out_12_13,
	output logic [63:0]           out_14_15
);

	s20_pkg::rounds_t double_rounds_q;
	logic             feed_forward_q;
	s20_pkg::cmd_t    cmd;
	s20_pkg::state_t  in_words;
	s20_pkg::state_t  out_words;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_rounds_q <= s20_pkg::RESET_DOUBLE_ROUNDS;
			feed_forward_q  <= s20_pkg::RESET_FEED_FORWARD;
		end else if (cfg_we) begin
			case (cfg_index)
				s20_pkg::CFG_DOUBLE_ROUNDS: double_rounds_q <= cfg_wdata;
				s20_pkg::CFG_FEED_FORWARD:  feed_forward_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign in_words = {words_14_15, words_12_13, words_10_11, words_8_9,
		words_6_7, words_4_5, words_2_3, words_0_1};

	assign {out_14_15, out_12_13, out_10_11, out_8_9,
		out_6_7, out_4_5, out_2_3, out_0_1} = out_words;

	s20_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.double_rounds (double_rounds_q),
		.cmd           (cmd)
	);

	s20_datapath u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.feed_forward (feed_forward_q),
		.in_words     (in_words),
		.out_words    (out_words)
	);

endmodule

### rtl/s20_checker.sv
// ----------------------------------------------------------------------------
// s20_checker
// port-level checks on the salsa20 block core
// ----------------------------------------------------------------------------
module s20_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] out_0_1
);

	// busy right after taking a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted beat");

	// leaving busy always presents a result
	a_result_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("input released without a result");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_0_1))
		else $error("output changed while stalled");

endmodule

bind salsa20_core s20_checker u_s20_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_0_1   (out_0_1)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for salsa20_core: directed and random 512-bit blocks
// over double-round counts 0 to 4 and 10 to 15 with feed-forward on and off, each result
// predicted in the bench and compared field by field at the output handshake
// ----------------------------------------------------------------------------
module tb_top;
	import s20_pkg::*;

	typedef logic [7:0][63:0] blk_t;

	localparam cfg_index_t CFG_SPARE_2 = 2'd2;
	localparam cfg_index_t CFG_SPARE_3 = 2'd3;
	localparam word_t SIGMA_0 = 32'h61707865;
	localparam word_t SIGMA_1 = 32'h3320646e;
	localparam word_t SIGMA_2 = 32'h79622d32;
	localparam word_t SIGMA_3 = 32'h6b206574;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned MAX_REPORTS = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = CFG_DOUBLE_ROUNDS;
	cfg_data_t cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	blk_t in_blk = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] out_0_1, out_2_3, out_4_5, out_6_7;
	logic [63:0] out_8_9, out_10_11, out_12_13, out_14_15;

	// bench copy of the registers
	rounds_t rounds_cfg = RESET_DOUBLE_ROUNDS;
	logic ff_cfg = RESET_FEED_FORWARD;

	blk_t blocks_to_send[$];
	blk_t pending_blocks[$];

	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned n_queued = 0;
	int unsigned n_blocks_in = 0;
	int unsigned n_blocks_out = 0;
	int unsigned n_mismatches = 0;
	int unsigned n_settings = 0;
	int unsigned idle_cycles = 0;
	logic [15:0] rounds_seen = '0;
	logic [1:0] ff_seen = '0;

	salsa20_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.words_0_1(in_blk[0]),
		.words_2_3(in_blk[1]),
		.words_4_5(in_blk[2]),
		.words_6_7(in_blk[3]),
		.words_8_9(in_blk[4]),
		.words_10_11(in_blk[5]),
		.words_12_13(in_blk[6]),
		.words_14_15(in_blk[7]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_0_1(out_0_1),
		.out_2_3(out_2_3),
		.out_4_5(out_4_5),
		.out_6_7(out_6_7),
		.out_8_9(out_8_9),
		.out_10_11(out_10_11),
		.out_12_13(out_12_13),
		.out_14_15(out_14_15)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t quarter_mix(state_t s, int a, int b, int c, int d);
		s[b] = s[b] ^ rotl(s[a] + s[d], 7);
		s[c] = s[c] ^ rotl(s[b] + s[a], 9);
		s[d] = s[d] ^ rotl(s[c] + s[b], 13);
		s[a] = s[a] ^ rotl(s[d] + s[c], 18);
		return s;
	endfunction

	function automatic state_t salsa_block(state_t init, rounds_t nr, logic ff);
		state_t s;
		s = init;
		for (int r = 0; r < nr; r++) begin
			// columns
			s = quarter_mix(s, 0, 4, 8, 12);
			s = quarter_mix(s, 5, 9, 13, 1);
			s = quarter_mix(s, 10, 14, 2, 6);
			s = quarter_mix(s, 15, 3, 7, 11);
			// rows
			s = quarter_mix(s, 0, 1, 2, 3);
			s = quarter_mix(s, 5, 6, 7, 4);
			s = quarter_mix(s, 10, 11, 8, 9);
			s = quarter_mix(s, 15, 12, 13, 14);
		end
		if (ff) begin
			for (int k = 0; k < NWORDS; k++)
				s[k] = s[k] + init[k];
		end
		return s;
	endfunction

	function automatic blk_t make_block(word_t even, word_t odd);
		blk_t b;
		for (int i = 0; i < 8; i++)
			b[i] = {odd, even};
		return b;
	endfunction

	function automatic blk_t index_block();
		blk_t b;
		for (int i = 0; i < 8; i++)
			b[i] = {32'(2 * i + 1), 32'(2 * i)};
		return b;
	endfunction

	function automatic blk_t rand_block();
		blk_t b;
		for (int i = 0; i < 8; i++)
			b[i] = {$urandom, $urandom};
		// keystream layout with the sigma constants on the diagonal
		if ($urandom_range(3) == 0) begin
			b[0][31:0] = SIGMA_0;
			b[2][63:32] = SIGMA_1;
			b[5][31:0] = SIGMA_2;
			b[7][63:32] = SIGMA_3;
		end
		return b;
	endfunction

	task automatic report_mismatch(string msg);
		if (n_mismatches < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		n_mismatches++;
	endtask

	// input side: accept, predict, then hold or load the next beat
	always @(posedge clk) begin : drive_blocks
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_blocks.push_back(blk_t'(salsa_block(state_t'(in_blk), rounds_cfg,
					ff_cfg)));
				rounds_seen[rounds_cfg] = 1'b1;
				ff_seen[ff_cfg] = 1'b1;
				n_blocks_in++;
			end
			if (!in_valid || !in_stall) begin
				if (blocks_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					in_blk <= blocks_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		blk_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_14_15, out_12_13, out_10_11, out_8_9,
				out_6_7, out_4_5, out_2_3, out_0_1};
			n_blocks_out++;
			if (pending_blocks.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected: %h", got));
			end else begin
				want = pending_blocks.pop_front();
				for (int i = 0; i < 8; i++) begin
					if (got[i] !== want[i])
						report_mismatch($sformatf("beat %0d field %0d got %h want %h",
							n_blocks_out, i, got[i], want[i]));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d results outstanding", idle_cycles,
				pending_blocks.size());
			$display("salsa20_core test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_block(blk_t b);
		while (blocks_to_send.size() >= 2)
			@(posedge clk);
		blocks_to_send.push_back(b);
		n_queued++;
	endtask

	task automatic wait_drained();
		while (n_blocks_in != n_queued || pending_blocks.size() != 0)
			@(posedge clk);
		repeat (2 * rounds_cfg + 4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, cfg_data_t d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_DOUBLE_ROUNDS)
			rounds_cfg = d;
		else if (idx == CFG_FEED_FORWARD)
			ff_cfg = d[0];
	endtask

	task automatic set_mode(rounds_t nr, logic ff);
		cfg_data_t d;
		wait_drained();
		// upper data bits are don't-care for the feed-forward flag
		d = cfg_data_t'($urandom);
		d[0] = ff;
		if ($urandom_range(1)) begin
			write_reg(CFG_DOUBLE_ROUNDS, nr);
			write_reg(CFG_FEED_FORWARD, d);
		end else begin
			write_reg(CFG_FEED_FORWARD, d);
			write_reg(CFG_DOUBLE_ROUNDS, nr);
		end
		n_settings++;
	endtask

	task automatic test_reset_setting();
		send_block(make_block(32'h0, 32'h0));
		send_block(make_block(32'hFFFFFFFF, 32'hFFFFFFFF));
		send_block(make_block(32'h55555555, 32'hAAAAAAAA));
		send_block(make_block(32'hFFFFFFFF, 32'h0));
		send_block(make_block(32'h0, 32'hFFFFFFFF));
		send_block(index_block());
	endtask

	task automatic test_round_extremes();
		set_mode(4'd1, 1'b0);
		send_block(make_block(32'hFFFFFFFF, 32'hFFFFFFFF));
		send_block(index_block());
		set_mode(4'd10, 1'b1);
		send_block(index_block());
		send_block(make_block(32'hAAAAAAAA, 32'h55555555));
	endtask

	task automatic test_zero_rounds();
		set_mode(4'd0, 1'b0);
		send_block(make_block(32'hFFFFFFFF, 32'hFFFFFFFF));
		send_block(rand_block());
		// doubling wraps at 2^32
		set_mode(4'd0, 1'b1);
		send_block(make_block(32'hFFFFFFFF, 32'hFFFFFFFF));
		send_block(make_block(32'h80000000, 32'h7FFFFFFF));
	endtask

	task automatic test_over_ten();
		set_mode(4'd15, 1'b1);
		send_block(rand_block());
		set_mode(4'd11, 1'b0);
		send_block(index_block());
	endtask

	task automatic test_spare_index();
		set_mode(4'd2, 1'b1);
		write_reg(CFG_SPARE_2, 4'hF);
		write_reg(CFG_SPARE_3, 4'h0);
		send_block(rand_block());
		send_block(make_block(32'h0, 32'hFFFFFFFF));
	endtask

	task automatic test_random_traffic(int unsigned gap, int unsigned stall, int unsigned n);
		int unsigned sent;
		int unsigned seg;
		int unsigned pick;
		rounds_t nr;
		send_gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < n) begin
			// mostly short round counts, the extremes now and then
			pick = $urandom_range(99);
			if (pick < 8)
				nr = 4'd0;
			else if (pick < 14)
				nr = rounds_t'($urandom_range(15, 11));
			else if (pick < 20)
				nr = 4'd10;
			else
				nr = rounds_t'($urandom_range(4, 1));
			set_mode(nr, 1'($urandom_range(1)));
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, cfg_data_t'($urandom));
			seg = $urandom_range(60, 20);
			repeat (seg) send_block(rand_block());
			sent += seg;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 7;
		stall_pct = 78;
		test_reset_setting();
		test_round_extremes();
		test_zero_rounds();
		test_over_ten();
		test_spare_index();
		test_random_traffic(7, 78, 560);
		test_random_traffic(78, 7, 560);
		test_random_traffic(0, 0, 560);
		wait_drained();
		$display("%0d blocks sent, %0d results checked, %0d register settings", n_blocks_in,
			n_blocks_out, n_settings);
		$display("double-round counts seen (bit per count) %b, feed-forward off/on %b",
			rounds_seen, ff_seen);
		if (n_mismatches == 0 && pending_blocks.size() == 0) begin
			$display("salsa20_core test passed");
		end else begin
			$display("%0d mismatches, %0d results missing", n_mismatches,
				pending_blocks.size());
			$display("salsa20_core test failed");
		end
		$finish;
	end

endmodule

### salsa20_core.f
rtl/s20_pkg.sv
rtl/s20_datapath.sv
rtl/s20_ctrl.sv
rtl/salsa20_core.sv
rtl/s20_checker.sv
dv/tb_top.sv
